### design/tgsa_pkg.sv
// Shared types, constants and the per-axis classification function of the tile grid address block.
package tgsa_pkg;

  localparam int MAX_DIM_DEFAULT = 4096;
  localparam int QDEPTH          = 4;
  localparam int RECIP_SHIFT     = 24;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TILES  = 2'd2;

  // Constants derived for one axis after a configuration write.
  typedef struct packed {
    logic [12:0] base;
    logic [12:0] extra;
    logic [25:0] span;
    logic [24:0] r_wide;
    logic [24:0] r_narrow;
  } axis_t;

  typedef struct packed {
    logic        busy;
    logic        ok;
    logic [12:0] w;
    logic [12:0] h;
    logic [12:0] n;
    axis_t       ax_row;
    axis_t       ax_col;
  } cfg_t;

  // One axis of a classified item: offset into its tile band and the divisor to use.
  typedef struct packed {
    logic [11:0] p;
    logic [24:0] r;
    logic [12:0] d;
    logic [11:0] off;
  } axis_item_t;

  typedef struct packed {
    logic       ok;
    axis_item_t row;
    axis_item_t col;
  } item_t;

  function automatic axis_item_t classify(input logic [11:0] pos, input axis_t a);
    axis_item_t t;
    logic       wide;
    wide = {14'b0, pos} < a.span;
    if (wide) begin
      t.p   = pos;
      t.r   = a.r_wide;
      t.d   = a.base + 13'd1;
      t.off = 12'd0;
    end else begin
      t.p   = pos - a.span[11:0];
      t.r   = a.r_narrow;
      t.d   = a.base;
      t.off = a.extra[11:0];
    end
    return t;
  endfunction

endpackage

### design/tile_grid_source_address.sv
// Top level of the tile grid source address generator.
//
// Each input beat on s_* carries one output pixel coordinate; each output beat on
// m_* carries the source pixel that fills it after the image is remapped into an
// n-by-n grid of subsampled tiles, plus the tile row and column that hold it.
// m_tuser is the ok flag; when it is low every other result field is zero.
//
// One coordinate is taken per clock while s_tready is high. A beat passes through the
// input register and the queue, then five arithmetic stages (reciprocal multiply,
// quotient times divisor, remainder fix-up, scaling by the tile factor, linear address).
//
// A write on the cfg port, and reset itself, starts a serial divider that derives
// tile sizes and their reciprocals one quotient bit per cycle over six divisions,
// during which s_tready stays low. Registers reset to width 1, height 1 and one tile.
//
// While a result waits with m_tready low the arithmetic pipeline holds; the four-entry
// queue and the input register keep taking beats until they are full, then s_tready drops.
module tile_grid_source_address #(
  parameter int MAX_DIM = tgsa_pkg::MAX_DIM_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // out_row [11:0], out_col [23:12]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // src_row, src_col, src_index, grid_row, grid_col
  output logic        m_tuser    // ok
);

  tgsa_pkg::cfg_t  cfg;
  tgsa_pkg::item_t f_item, q_item;
  logic push, q_full, q_empty, pop;

  tgsa_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg
  );

  tgsa_front u_front (
    .clk, .rst, .cfg, .s_tvalid, .s_tready, .s_tdata,
    .push, .q_full, .item(f_item)
  );

  tgsa_queue #(.DEPTH(tgsa_pkg::QDEPTH)) u_queue (
    .clk, .rst, .push, .din(f_item), .full(q_full),
    .pop, .empty(q_empty), .dout(q_item)
  );

  tgsa_back u_back (
    .clk, .rst, .cfg, .q_empty, .q_item, .pop,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  // No coordinate is taken while tile sizes are being recomputed.
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg.busy |-> !s_tready) else $error("input taken during divider run");

  // The input stage never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push) else $error("queue overflow");

  // A result that is not ok carries all-zero fields.
  a_zero_when_bad: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == 72'd0)) else $error("nonzero invalid result");

endmodule

### design/tgsa_cfg.sv
// Configuration registers and the shared serial divider that derives tile sizes and reciprocals.
module tgsa_cfg #(
  parameter int MAX_DIM = tgsa_pkg::MAX_DIM_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [12:0]    cfg_data,
  output tgsa_pkg::cfg_t cfg
);

  localparam int NUM_W    = tgsa_pkg::RECIP_SHIFT + 1;
  localparam int LAST_JOB = 5;
  localparam int STEPS    = NUM_W;

  logic [12:0] w, h, n;
  logic        busy;
  logic [2:0]  job;
  logic [4:0]  cnt;
  logic [12:0] rem;
  logic [NUM_W-1:0] quo;
  logic [NUM_W-1:0] num;
  logic [12:0] den;
  logic [13:0] rs;
  logic        ge;
  logic        ok;
  tgsa_pkg::axis_t ax_row, ax_col;

  // Jobs: height/n, width/n, then the four reciprocals of the tile sizes.
  always_comb begin
    num = NUM_W'(1) << tgsa_pkg::RECIP_SHIFT;
    unique case (job)
      3'd0: begin num = {12'b0, h}; den = n; end
      3'd1: begin num = {12'b0, w}; den = n; end
      3'd2: den = ax_row.base + 13'd1;
      3'd3: den = ax_row.base;
      3'd4: den = ax_col.base + 13'd1;
      3'd5: den = ax_col.base;
      default: den = n;
    endcase
    rs = {rem, quo[NUM_W-1]};
    ge = rs >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w    <= 13'd1;
      h    <= 13'd1;
      n    <= 13'd1;
      busy <= 1'b1;
      job  <= 3'd0;
      cnt  <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        tgsa_pkg::REG_WIDTH:  w <= cfg_data;
        tgsa_pkg::REG_HEIGHT: h <= cfg_data;
        tgsa_pkg::REG_TILES:  n <= cfg_data;
        default: ;
      endcase
      busy <= 1'b1;
      job  <= 3'd0;
      cnt  <= 5'd0;
    end else if (busy) begin
      if (cnt == 5'(STEPS + 1)) begin
        cnt <= 5'd0;
        job <= job + 3'd1;
        if (job == 3'(LAST_JOB)) busy <= 1'b0;
      end else begin
        cnt <= cnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cnt == 5'd0) begin
      rem <= 13'd0;
      quo <= num;
    end else if (cnt <= 5'(STEPS)) begin
      rem <= ge ? 13'(rs - {1'b0, den}) : rs[12:0];
      quo <= {quo[NUM_W-2:0], ge};
    end else begin
      case (job)
        3'd0: begin ax_row.base <= quo[12:0]; ax_row.extra <= rem; end
        3'd1: begin ax_col.base <= quo[12:0]; ax_col.extra <= rem; end
        3'd2: ax_row.r_wide   <= quo;
        3'd3: ax_row.r_narrow <= quo;
        3'd4: ax_col.r_wide   <= quo;
        3'd5: ax_col.r_narrow <= quo;
        default: ;
      endcase
    end
    ax_row.span <= 26'(ax_row.extra * (ax_row.base + 13'd1));
    ax_col.span <= 26'(ax_col.extra * (ax_col.base + 13'd1));
    ok <= (n != 13'd0) && (int'(w) <= MAX_DIM) && (int'(h) <= MAX_DIM) &&
          (ax_row.base != 13'd0) && (ax_col.base != 13'd0);
  end

  assign cfg = '{busy: busy, ok: ok, w: w, h: h, n: n, ax_row: ax_row, ax_col: ax_col};

endmodule

### design/tgsa_front.sv
// Input stage: takes coordinate beats, checks them and picks the tile band on each axis.
module tgsa_front (
  input  logic            clk,
  input  logic            rst,
  input  tgsa_pkg::cfg_t  cfg,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [23:0]     s_tdata,
  output logic            push,
  input  logic            q_full,
  output tgsa_pkg::item_t item
);

  logic [11:0] row, col;
  logic        fv;
  tgsa_pkg::item_t cls;

  assign row = s_tdata[11:0];
  assign col = s_tdata[23:12];

  always_comb begin
    cls.ok  = cfg.ok && ({1'b0, row} < cfg.h) && ({1'b0, col} < cfg.w);
    cls.row = tgsa_pkg::classify(row, cfg.ax_row);
    cls.col = tgsa_pkg::classify(col, cfg.ax_col);
  end

  assign push     = fv && !q_full;
  assign s_tready = !cfg.busy && (!fv || !q_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) item <= cls;
  end

endmodule

### design/tgsa_queue.sv
// Small register queue between the input stage and the arithmetic pipeline.
module tgsa_queue #(
  parameter int DEPTH = tgsa_pkg::QDEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tgsa_pkg::item_t din,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output tgsa_pkg::item_t dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tgsa_pkg::item_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] count;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      if (pop)  rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

endmodule

### design/tgsa_back.sv
// Arithmetic pipeline: reciprocal division, remainder fix-up, scaling and linear address.
module tgsa_back (
  input  logic            clk,
  input  logic            rst,
  input  tgsa_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  tgsa_pkg::item_t q_item,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [71:0]     m_tdata,
  output logic            m_tuser
);

  localparam int SH = tgsa_pkg::RECIP_SHIFT;

  logic        adv;
  logic        v1, v2, v3, v4, v5;
  logic        ok1, ok2, ok3, ok4, ok5;
  tgsa_pkg::axis_item_t a1 [2];
  logic [36:0] prod1 [2];
  logic [11:0] p1 [2], off1 [2];
  logic [12:0] d1 [2];
  logic [11:0] p2 [2], q2 [2], off2 [2];
  logic [12:0] d2 [2];
  logic [24:0] qd2 [2];
  logic [11:0] tile3 [2], lcl3 [2];
  logic [11:0] tile4 [2], src4 [2];
  logic [13:0] rem [2];
  logic        fix [2];
  logic [11:0] grid_row, grid_col, src_row, src_col;
  logic [23:0] src_index;

  assign adv      = !v5 || m_tready;
  assign pop      = adv && !q_empty;
  assign a1[0]    = q_item.row;
  assign a1[1]    = q_item.col;
  assign m_tvalid = v5;
  assign m_tuser  = ok5;
  assign m_tdata  = {grid_col, grid_row, src_index, src_col, src_row};

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem[i] = {2'b0, p2[i]} - qd2[i][13:0];
      fix[i] = rem[i] >= {1'b0, d2[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5} <= '0;
    end else if (adv) begin
      {v1, v2, v3, v4, v5} <= {!q_empty, v1, v2, v3, v4};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {ok1, ok2, ok3, ok4, ok5} <= {q_item.ok, ok1, ok2, ok3, ok4};
      for (int i = 0; i < 2; i++) begin
        prod1[i] <= a1[i].p * a1[i].r;
        p1[i]    <= a1[i].p;
        d1[i]    <= a1[i].d;
        off1[i]  <= a1[i].off;
        q2[i]    <= prod1[i][SH+11:SH];
        qd2[i]   <= prod1[i][SH+11:SH] * d1[i];
        p2[i]    <= p1[i];
        d2[i]    <= d1[i];
        off2[i]  <= off1[i];
        tile3[i] <= off2[i] + q2[i] + (fix[i] ? 12'd1 : 12'd0);
        lcl3[i]  <= fix[i] ? 12'(rem[i] - {1'b0, d2[i]}) : rem[i][11:0];
        tile4[i] <= tile3[i];
        src4[i]  <= 12'(lcl3[i] * cfg.n);
      end
      // Position, divisor and band offset travel alongside the quotient stage by stage.
      if (ok4) begin
        src_row   <= src4[0];
        src_col   <= src4[1];
        src_index <= {12'b0, src4[0]} * {11'b0, cfg.w} + {12'b0, src4[1]};
        grid_row  <= tile4[0];
        grid_col  <= tile4[1];
      end else begin
        src_row   <= '0;
        src_col   <= '0;
        src_index <= '0;
        grid_row  <= '0;
        grid_col  <= '0;
      end
    end
  end

endmodule
